### sv/ahlf_pkg.sv
// Shared types and constants for the audio high-pass / limiter / framer core.
// Holds the register map, the controller states, the byte selects and the
// fixed widths of the sample arithmetic. No dependencies.
package ahlf_pkg;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_BYPASS         = 3'd0,
        REG_RAW_SHIFT      = 3'd1,
        REG_HPF_COEFF      = 3'd2,
        REG_GAIN           = 3'd3,
        REG_KNEE_THRESHOLD = 3'd4,
        REG_KNEE_SLOPE     = 3'd5,
        REG_FRAME_LEN      = 3'd6
    } reg_index_t;

    // Configuration register widths
    localparam int SHIFT_W = 3;
    localparam int COEFF_W = 16;
    localparam int GAIN_W  = 5;
    localparam int THR_W   = 15;
    localparam int SLOPE_W = 9;
    localparam int FLEN_W  = 9;

    typedef struct packed {
        logic               bypass;
        logic [SHIFT_W-1:0] raw_shift;
        logic [COEFF_W-1:0] hpf_coeff;
        logic [GAIN_W-1:0]  gain;
        logic [THR_W-1:0]   knee_threshold;
        logic [SLOPE_W-1:0] knee_slope;
        logic [FLEN_W-1:0]  frame_len;
    } cfg_t;

    // Reset values
    localparam logic               RST_BYPASS         = 1'b1;
    localparam logic [SHIFT_W-1:0] RST_RAW_SHIFT      = 3'd3;
    localparam logic [COEFF_W-1:0] RST_HPF_COEFF      = 16'd63845;
    localparam logic [GAIN_W-1:0]  RST_GAIN           = 5'd4;
    localparam logic [THR_W-1:0]   RST_KNEE_THRESHOLD = 15'd20000;
    localparam logic [SLOPE_W-1:0] RST_KNEE_SLOPE     = 9'd64;
    localparam logic [FLEN_W-1:0]  RST_FRAME_LEN      = 9'd256;

    // Arithmetic widths
    localparam int FILT_W     = 28;            // filter state, signed Q.12
    localparam int FRAC_SH    = 12;            // Q.12 fraction bits
    localparam int COEFF_SH   = 16;            // Q0.16 coefficient fraction bits
    localparam int GPROD_W    = FILT_W + 6;    // filter state times gain, signed
    localparam int MAG_W      = GPROD_W - 1;   // magnitude of that product
    localparam int KPROD_W    = MAG_W + SLOPE_W;
    localparam int SLOPE_SH   = 8;             // Q8 slope
    localparam int KMAG_W     = MAG_W + 2;
    localparam int Q_W        = KMAG_W - FRAC_SH;
    localparam int PCM_W      = 16;
    localparam int LEN_W      = 16;

    localparam int FILT_MAX_VAL = 134217727;
    localparam int FILT_MIN_VAL = -134217728;
    localparam int PCM_MAX_VAL  = 32767;
    localparam int PCM_MIN_VAL  = -32768;
    localparam int PCM_NEG_MAG  = 32768;
    localparam int RND_HALF_VAL = 32768;

    // Frame header bytes
    localparam logic [7:0] HDR_SYNC0 = 8'h55;
    localparam logic [7:0] HDR_SYNC1 = 8'hAA;
    localparam logic [7:0] HDR_TAG_S = 8'h53;
    localparam logic [7:0] HDR_TAG_1 = 8'h31;

    // Byte slots of one sample's output run
    typedef enum logic [2:0] {
        BYTE_SYNC0  = 3'd0,
        BYTE_SYNC1  = 3'd1,
        BYTE_TAG_S  = 3'd2,
        BYTE_TAG_1  = 3'd3,
        BYTE_LEN_LO = 3'd4,
        BYTE_LEN_HI = 3'd5,
        BYTE_PCM_LO = 3'd6,
        BYTE_PCM_HI = 3'd7
    } byte_sel_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FILT,
        ST_GAIN,
        ST_KNEE,
        ST_PACK,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic      load_sample;
        logic      sum_en;
        logic      filt_en;
        logic      gain_en;
        logic      knee_en;
        logic      pack_en;
        logic      out_load;
        logic      frame_adv;
        byte_sel_t byte_sel;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic frame_start;
    } dp_sts_t;

endpackage

### sv/audio_hpf_limiter_framer_core.sv
// Audio DC-blocking high-pass filter with soft-knee limiter and byte framer.
// Each accepted ADC sample is centered, then either shifted (raw mode) or run
// through a first-order high-pass, pre-gain and soft knee, and sent as a
// 16-bit word, low byte first; a six-byte header (55 AA 'S' '1' len_lo
// len_hi) opens each frame. The block works on one sample at a time: after
// acceptance the sample passes through the sum, pole-multiply, gain, knee and
// pack registers of the controller-driven datapath, then one byte leaves per
// cycle into the output register unless a downstream stall on m_ready holds
// it; the three dependent multiplies and the single output byte register set
// the pace of each sample. The next sample is accepted while the last byte of
// the previous one is still waiting on m_ready. Registers sit on an APB port
// at byte address 4*index; filter state and frame position persist across
// frames and clear only on reset.
module audio_hpf_limiter_framer_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAME_MAX   = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ahlf_pkg::ADDR_W-1:0]   paddr,
    input  logic [ahlf_pkg::DATA_W-1:0]   pwdata,
    output logic [ahlf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SAMPLE_BITS-1:0]        s_adc_sample,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_run_last,
    output logic                          m_frame_end
);

    ahlf_pkg::cfg_t    cfg;
    ahlf_pkg::dp_cmd_t cmd;
    ahlf_pkg::dp_sts_t sts;

    // Configuration registers
    ahlf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    ahlf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Arithmetic and framing
    ahlf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAME_MAX   (FRAME_MAX)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .s_adc_sample (s_adc_sample),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_frame_end  (m_frame_end)
    );

endmodule

### sv/ahlf_cfg.sv
// APB register file for the audio high-pass / limiter / framer core.
// Holds the seven configuration registers; depends on ahlf_pkg.
module ahlf_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ahlf_pkg::ADDR_W-1:0]   paddr,
    input  logic [ahlf_pkg::DATA_W-1:0]   pwdata,
    output logic [ahlf_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ahlf_pkg::cfg_t                cfg
);

    ahlf_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bypass         <= ahlf_pkg::RST_BYPASS;
            cfg_reg.raw_shift      <= ahlf_pkg::RST_RAW_SHIFT;
            cfg_reg.hpf_coeff      <= ahlf_pkg::RST_HPF_COEFF;
            cfg_reg.gain           <= ahlf_pkg::RST_GAIN;
            cfg_reg.knee_threshold <= ahlf_pkg::RST_KNEE_THRESHOLD;
            cfg_reg.knee_slope     <= ahlf_pkg::RST_KNEE_SLOPE;
            cfg_reg.frame_len      <= ahlf_pkg::RST_FRAME_LEN;
        end else if (wr_en) begin
            case (reg_idx)
                ahlf_pkg::REG_BYPASS:
                    cfg_reg.bypass <= pwdata[0];
                ahlf_pkg::REG_RAW_SHIFT:
                    cfg_reg.raw_shift <= pwdata[ahlf_pkg::SHIFT_W-1:0];
                ahlf_pkg::REG_HPF_COEFF:
                    cfg_reg.hpf_coeff <= pwdata[ahlf_pkg::COEFF_W-1:0];
                ahlf_pkg::REG_GAIN:
                    cfg_reg.gain <= pwdata[ahlf_pkg::GAIN_W-1:0];
                ahlf_pkg::REG_KNEE_THRESHOLD:
                    cfg_reg.knee_threshold <= pwdata[ahlf_pkg::THR_W-1:0];
                ahlf_pkg::REG_KNEE_SLOPE:
                    cfg_reg.knee_slope <= pwdata[ahlf_pkg::SLOPE_W-1:0];
                ahlf_pkg::REG_FRAME_LEN:
                    cfg_reg.frame_len <= pwdata[ahlf_pkg::FLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            ahlf_pkg::REG_BYPASS:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.bypass);
            ahlf_pkg::REG_RAW_SHIFT:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.raw_shift);
            ahlf_pkg::REG_HPF_COEFF:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.hpf_coeff);
            ahlf_pkg::REG_GAIN:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.gain);
            ahlf_pkg::REG_KNEE_THRESHOLD:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.knee_threshold);
            ahlf_pkg::REG_KNEE_SLOPE:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.knee_slope);
            ahlf_pkg::REG_FRAME_LEN:
                prdata = ahlf_pkg::DATA_W'(cfg_reg.frame_len);
            default:
                prdata = '0;
        endcase
    end

endmodule

### sv/ahlf_ctrl.sv
// Sequencing controller for the audio high-pass / limiter / framer core.
// Steps one sample through the datapath stages, then emits its byte run;
// depends on ahlf_pkg.
module ahlf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ahlf_pkg::dp_sts_t sts,
    output ahlf_pkg::dp_cmd_t cmd
);

    ahlf_pkg::ctrl_state_t state_reg, state_next;
    ahlf_pkg::byte_sel_t   byte_reg, byte_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;

    assign m_valid   = out_valid_reg;
    assign slot_free = !out_valid_reg || m_ready;

    // State, byte slot and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ahlf_pkg::ST_IDLE;
            byte_reg      <= ahlf_pkg::BYTE_SYNC0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = byte_reg;
        case (state_reg)
            ahlf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ahlf_pkg::ST_SUM;
                end
            end
            ahlf_pkg::ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ahlf_pkg::ST_FILT;
            end
            ahlf_pkg::ST_FILT: begin
                cmd.filt_en = 1'b1;
                state_next  = ahlf_pkg::ST_GAIN;
            end
            ahlf_pkg::ST_GAIN: begin
                cmd.gain_en = 1'b1;
                state_next  = ahlf_pkg::ST_KNEE;
            end
            ahlf_pkg::ST_KNEE: begin
                cmd.knee_en = 1'b1;
                state_next  = ahlf_pkg::ST_PACK;
            end
            ahlf_pkg::ST_PACK: begin
                // Start with the header when this sample opens a frame
                cmd.pack_en = 1'b1;
                byte_next   = sts.frame_start ? ahlf_pkg::BYTE_SYNC0
                                              : ahlf_pkg::BYTE_PCM_LO;
                state_next  = ahlf_pkg::ST_EMIT;
            end
            ahlf_pkg::ST_EMIT: begin
                // Load one byte whenever the output slot frees up
                if (slot_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (byte_reg == ahlf_pkg::BYTE_PCM_HI) begin
                        cmd.frame_adv = 1'b1;
                        state_next    = ahlf_pkg::ST_IDLE;
                    end else begin
                        byte_next = ahlf_pkg::byte_sel_t'(byte_reg + 3'd1);
                    end
                end
            end
            default: begin
                state_next = ahlf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ahlf_dp.sv
// Datapath for the audio high-pass / limiter / framer core: bias removal,
// high-pass filter, gain, soft knee, saturation, frame counter and byte mux.
// Depends on ahlf_pkg; driven by ahlf_ctrl commands.
module ahlf_dp #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAME_MAX   = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ahlf_pkg::cfg_t         cfg,
    input  ahlf_pkg::dp_cmd_t      cmd,
    output ahlf_pkg::dp_sts_t      sts,
    input  logic [SAMPLE_BITS-1:0] s_adc_sample,
    output logic [7:0]             m_out_byte,
    output logic                   m_run_last,
    output logic                   m_frame_end
);

    localparam int XC_W   = SAMPLE_BITS;
    localparam int DIFF_W = XC_W + 1;
    localparam int SUM_W  = ((DIFF_W + ahlf_pkg::FRAC_SH > ahlf_pkg::FILT_W) ?
                             DIFF_W + ahlf_pkg::FRAC_SH : ahlf_pkg::FILT_W) + 1;
    localparam int PROD_W = SUM_W + ahlf_pkg::COEFF_W + 1;
    localparam int YW_W   = PROD_W - ahlf_pkg::COEFF_SH;
    localparam int RAW_W  = SAMPLE_BITS + 8;
    localparam int POS_W  = $clog2(FRAME_MAX + 1);
    localparam int LEN_W  = ahlf_pkg::LEN_W;
    localparam int MAG_W  = ahlf_pkg::MAG_W;
    localparam int KMAG_W = ahlf_pkg::KMAG_W;
    localparam int Q_W    = ahlf_pkg::Q_W;
    localparam int PCM_W  = ahlf_pkg::PCM_W;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(ahlf_pkg::RND_HALF_VAL);
    localparam logic signed [YW_W-1:0]   Y_MAX    = YW_W'(ahlf_pkg::FILT_MAX_VAL);
    localparam logic signed [YW_W-1:0]   Y_MIN    = YW_W'(ahlf_pkg::FILT_MIN_VAL);
    localparam logic signed [RAW_W-1:0]  RAW_MAX  = RAW_W'(ahlf_pkg::PCM_MAX_VAL);
    localparam logic signed [RAW_W-1:0]  RAW_MIN  = RAW_W'(ahlf_pkg::PCM_MIN_VAL);
    localparam logic [Q_W-1:0]           Q_POS_MAX = Q_W'(ahlf_pkg::PCM_MAX_VAL);
    localparam logic [Q_W-1:0]           Q_NEG_MAX = Q_W'(ahlf_pkg::PCM_NEG_MAG);
    localparam logic [LEN_W-1:0]         LEN_MAX   = LEN_W'(FRAME_MAX);

    // Stored state and stage registers
    logic        [SAMPLE_BITS-1:0]        sample_reg;
    logic signed [XC_W-1:0]               prev_reg;
    logic signed [ahlf_pkg::FILT_W-1:0]   filter_out_reg;
    logic signed [SUM_W-1:0]              sum_reg;
    logic        [MAG_W-1:0]              mag_reg;
    logic                                 neg_reg;
    logic        [ahlf_pkg::KPROD_W-1:0]  knee_prod_reg;
    logic                                 over_reg;
    logic        [PCM_W-1:0]              pcm_reg;
    logic        [POS_W-1:0]              frame_pos_reg;
    logic        [7:0]                    out_byte_reg;
    logic                                 run_last_reg;
    logic                                 frame_end_reg;

    logic signed [XC_W-1:0]               xc;
    logic signed [DIFF_W-1:0]             diff;
    logic signed [SUM_W-1:0]              sum_next;
    logic signed [PROD_W-1:0]             prod;
    logic signed [PROD_W-1:0]             prod_rnd;
    logic signed [YW_W-1:0]               y_wide;
    logic signed [ahlf_pkg::FILT_W-1:0]   y_sat;
    logic signed [ahlf_pkg::GPROD_W-1:0]  gain_prod;
    logic signed [ahlf_pkg::GPROD_W-1:0]  gain_abs;
    logic        [MAG_W-1:0]              thr;
    logic        [MAG_W-1:0]              excess;
    logic        [KMAG_W-1:0]             kmag;
    logic        [Q_W-1:0]                q;
    logic        [PCM_W-1:0]              filt_pcm;
    logic signed [RAW_W-1:0]              raw_wide;
    logic        [PCM_W-1:0]              raw_pcm;
    logic        [LEN_W-1:0]              len_eff;
    logic                                 fend;
    logic        [7:0]                    byte_mux;

    // Center the sample: flip the top bit to subtract mid-scale
    assign xc   = {~sample_reg[SAMPLE_BITS-1], sample_reg[SAMPLE_BITS-2:0]};
    assign diff = DIFF_W'(xc) - DIFF_W'(prev_reg);

    // Filter input sum, Q.12
    assign sum_next = SUM_W'(filter_out_reg) + (SUM_W'(diff) <<< ahlf_pkg::FRAC_SH);

    // Pole multiply, round to nearest, saturate to filter width
    assign prod     = PROD_W'(sum_reg) * PROD_W'($signed({1'b0, cfg.hpf_coeff}));
    assign prod_rnd = prod + RND_HALF;
    assign y_wide   = prod_rnd[PROD_W-1:ahlf_pkg::COEFF_SH];

    always_comb begin
        if (y_wide > Y_MAX) begin
            y_sat = ahlf_pkg::FILT_W'(Y_MAX);
        end else if (y_wide < Y_MIN) begin
            y_sat = ahlf_pkg::FILT_W'(Y_MIN);
        end else begin
            y_sat = ahlf_pkg::FILT_W'(y_wide);
        end
    end

    // Pre-gain and magnitude
    assign gain_prod = ahlf_pkg::GPROD_W'(filter_out_reg)
                     * ahlf_pkg::GPROD_W'($signed({1'b0, cfg.gain}));
    assign gain_abs  = gain_prod[ahlf_pkg::GPROD_W-1] ? -gain_prod : gain_prod;

    // Knee excess times slope
    assign thr    = MAG_W'({cfg.knee_threshold, {ahlf_pkg::FRAC_SH{1'b0}}});
    assign excess = mag_reg - thr;

    // Apply knee, drop fraction, saturate with sign restored
    assign kmag = over_reg ? KMAG_W'(thr) + KMAG_W'(knee_prod_reg >> ahlf_pkg::SLOPE_SH)
                           : KMAG_W'(mag_reg);
    assign q    = kmag[KMAG_W-1:ahlf_pkg::FRAC_SH];

    always_comb begin
        if (neg_reg) begin
            filt_pcm = (q > Q_NEG_MAX) ? PCM_W'(ahlf_pkg::PCM_MIN_VAL) : PCM_W'(-q);
        end else begin
            filt_pcm = (q > Q_POS_MAX) ? PCM_W'(ahlf_pkg::PCM_MAX_VAL) : PCM_W'(q);
        end
    end

    // Raw path: shift and saturate
    assign raw_wide = RAW_W'(xc) <<< cfg.raw_shift;

    always_comb begin
        if (raw_wide > RAW_MAX) begin
            raw_pcm = PCM_W'(RAW_MAX);
        end else if (raw_wide < RAW_MIN) begin
            raw_pcm = PCM_W'(RAW_MIN);
        end else begin
            raw_pcm = PCM_W'(raw_wide);
        end
    end

    // Effective frame length and end of frame
    always_comb begin
        if (cfg.frame_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (LEN_W'(cfg.frame_len) > LEN_MAX) begin
            len_eff = LEN_MAX;
        end else begin
            len_eff = LEN_W'(cfg.frame_len);
        end
    end

    assign fend = ({1'b0, LEN_W'(frame_pos_reg)} + (LEN_W + 1)'(1)) >= {1'b0, len_eff};
    assign sts.frame_start = (frame_pos_reg == '0);

    // Byte select
    always_comb begin
        case (cmd.byte_sel)
            ahlf_pkg::BYTE_SYNC0:  byte_mux = ahlf_pkg::HDR_SYNC0;
            ahlf_pkg::BYTE_SYNC1:  byte_mux = ahlf_pkg::HDR_SYNC1;
            ahlf_pkg::BYTE_TAG_S:  byte_mux = ahlf_pkg::HDR_TAG_S;
            ahlf_pkg::BYTE_TAG_1:  byte_mux = ahlf_pkg::HDR_TAG_1;
            ahlf_pkg::BYTE_LEN_LO: byte_mux = len_eff[7:0];
            ahlf_pkg::BYTE_LEN_HI: byte_mux = len_eff[15:8];
            ahlf_pkg::BYTE_PCM_LO: byte_mux = pcm_reg[7:0];
            ahlf_pkg::BYTE_PCM_HI: byte_mux = pcm_reg[15:8];
            default:               byte_mux = '0;
        endcase
    end

    // Filter state and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_out_reg <= '0;
            prev_reg       <= '0;
            frame_pos_reg  <= '0;
        end else begin
            if (cmd.filt_en && !cfg.bypass) begin
                filter_out_reg <= y_sat;
                prev_reg       <= xc;
            end
            if (cmd.frame_adv) begin
                frame_pos_reg <= fend ? '0 : frame_pos_reg + POS_W'(1);
            end
        end
    end

    // Stage and output payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_adc_sample;
        end
        if (cmd.sum_en) begin
            sum_reg <= sum_next;
        end
        if (cmd.gain_en) begin
            neg_reg <= gain_prod[ahlf_pkg::GPROD_W-1];
            mag_reg <= gain_abs[MAG_W-1:0];
        end
        if (cmd.knee_en) begin
            over_reg      <= mag_reg > thr;
            knee_prod_reg <= ahlf_pkg::KPROD_W'(excess) * ahlf_pkg::KPROD_W'(cfg.knee_slope);
        end
        if (cmd.pack_en) begin
            pcm_reg <= cfg.bypass ? raw_pcm : filt_pcm;
        end
        if (cmd.out_load) begin
            out_byte_reg  <= byte_mux;
            run_last_reg  <= (cmd.byte_sel == ahlf_pkg::BYTE_PCM_HI);
            frame_end_reg <= (cmd.byte_sel == ahlf_pkg::BYTE_PCM_HI) && fend;
        end
    end

    assign m_out_byte  = out_byte_reg;
    assign m_run_last  = run_last_reg;
    assign m_frame_end = frame_end_reg;

endmodule
